// ----- design/ets_pkg.sv -----
// Shared types and constants for the expression token scanner.
`default_nettype none

package ets_pkg;

    localparam int TOKEN_BUFFER_DEF = 2048;
    localparam int LEN_W            = 11;
    localparam int LEN_MAX          = 2047;
    localparam int KIND_W           = 5;
    localparam int FIFO_DEPTH       = 4;
    localparam int OUT_DATA_W       = 24;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind K_INVALID = 5'd0;
    localparam t_kind K_EOF     = 5'd1;
    localparam t_kind K_IDENT   = 5'd2;
    localparam t_kind K_INT     = 5'd3;
    localparam t_kind K_LPAREN  = 5'd4;
    localparam t_kind K_RPAREN  = 5'd5;
    localparam t_kind K_LBRACK  = 5'd6;
    localparam t_kind K_RBRACK  = 5'd7;
    localparam t_kind K_PLUS    = 5'd8;
    localparam t_kind K_MINUS   = 5'd9;
    localparam t_kind K_STAR    = 5'd10;
    localparam t_kind K_SLASH   = 5'd11;
    localparam t_kind K_MOD     = 5'd12;
    localparam t_kind K_SHL     = 5'd13;
    localparam t_kind K_SHR     = 5'd14;
    localparam t_kind K_AMP     = 5'd15;
    localparam t_kind K_PIPE    = 5'd16;
    localparam t_kind K_CARET   = 5'd17;
    localparam t_kind K_EQEQ    = 5'd18;
    localparam t_kind K_NEQ     = 5'd19;
    localparam t_kind K_GT      = 5'd20;
    localparam t_kind K_LT      = 5'd21;
    localparam t_kind K_GE      = 5'd22;
    localparam t_kind K_LE      = 5'd23;
    localparam t_kind K_ANDAND  = 5'd24;
    localparam t_kind K_OROR    = 5'd25;
    localparam t_kind K_BANG    = 5'd26;
    localparam t_kind K_QUEST   = 5'd27;
    localparam t_kind K_COLON   = 5'd28;
    localparam t_kind K_COMMA   = 5'd29;
    localparam t_kind K_ASSIGN  = 5'd30;
    localparam t_kind K_FN      = 5'd31;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_IDENT   = 3'd2,
        MODE_INT     = 3'd3,
        MODE_OP      = 3'd4
    } t_mode;

    typedef struct packed {
        t_kind            kind;
        logic [LEN_W-1:0] length;
        logic             too_long;
        logic             last;
    } t_token;

    // Tokens produced by one item, in order; cnt is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_push;

endpackage

`default_nettype wire

// ----- design/ets_scan_core.sv -----
// Input register, scanner state and per-byte token decision.
`default_nettype none

module ets_scan_core #(
    parameter int TOKEN_BUFFER = ets_pkg::TOKEN_BUFFER_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    output logic         o_ready,
    input  wire  [7:0]   i_byte,
    input  wire          i_eoi,
    input  wire          i_room,
    output ets_pkg::t_push o_push
);

    localparam int CAP_INT = (TOKEN_BUFFER - 1 > ets_pkg::LEN_MAX) ?
                             ets_pkg::LEN_MAX : TOKEN_BUFFER - 1;
    localparam logic [ets_pkg::LEN_W-1:0] LEN_CAP = ets_pkg::LEN_W'(CAP_INT);

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;

    localparam logic [1:0] KP_NONE = 2'd0;
    localparam logic [1:0] KP_F    = 2'd1;
    localparam logic [1:0] KP_FN   = 2'd2;
    localparam logic [1:0] KP_NOT  = 2'd3;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic ets_pkg::t_kind single_kind(input logic [7:0] c);
        ets_pkg::t_kind k;
        k = ets_pkg::K_INVALID;
        if (c == CH_AMP)       k = ets_pkg::K_AMP;
        else if (c == CH_PIPE) k = ets_pkg::K_PIPE;
        else if (c == CH_GT)   k = ets_pkg::K_GT;
        else if (c == CH_LT)   k = ets_pkg::K_LT;
        else if (c == CH_EQ)   k = ets_pkg::K_ASSIGN;
        else if (c == CH_BANG) k = ets_pkg::K_BANG;
        return k;
    endfunction

    function automatic ets_pkg::t_kind pair_kind(input logic [7:0] a, input logic [7:0] b);
        ets_pkg::t_kind k;
        k = ets_pkg::K_INVALID;
        if (a == CH_AMP && b == CH_AMP)        k = ets_pkg::K_ANDAND;
        else if (a == CH_PIPE && b == CH_PIPE) k = ets_pkg::K_OROR;
        else if (a == CH_GT && b == CH_GT)     k = ets_pkg::K_SHR;
        else if (a == CH_GT && b == CH_EQ)     k = ets_pkg::K_GE;
        else if (a == CH_LT && b == CH_LT)     k = ets_pkg::K_SHL;
        else if (a == CH_LT && b == CH_EQ)     k = ets_pkg::K_LE;
        else if (a == CH_EQ && b == CH_EQ)     k = ets_pkg::K_EQEQ;
        else if (a == CH_BANG && b == CH_EQ)   k = ets_pkg::K_NEQ;
        return k;
    endfunction

    function automatic ets_pkg::t_kind immediate_kind(input logic [7:0] c);
        ets_pkg::t_kind k;
        unique case (c)
            8'h28:   k = ets_pkg::K_LPAREN;
            8'h29:   k = ets_pkg::K_RPAREN;
            8'h5B:   k = ets_pkg::K_LBRACK;
            8'h5D:   k = ets_pkg::K_RBRACK;
            8'h2B:   k = ets_pkg::K_PLUS;
            8'h2D:   k = ets_pkg::K_MINUS;
            8'h2A:   k = ets_pkg::K_STAR;
            8'h2F:   k = ets_pkg::K_SLASH;
            8'h25:   k = ets_pkg::K_MOD;
            8'h5E:   k = ets_pkg::K_CARET;
            8'h3F:   k = ets_pkg::K_QUEST;
            8'h3A:   k = ets_pkg::K_COLON;
            8'h2C:   k = ets_pkg::K_COMMA;
            default: k = ets_pkg::K_INVALID;
        endcase
        return k;
    endfunction

    function automatic ets_pkg::t_token mk_tok(input ets_pkg::t_kind k,
                                               input logic [ets_pkg::LEN_W-1:0] len,
                                               input logic too);
        ets_pkg::t_token t;
        t.kind     = k;
        t.length   = len;
        t.too_long = too;
        t.last     = 1'b0;
        return t;
    endfunction

    // input register
    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_eoi;

    // scanner state
    ets_pkg::t_mode              r_mode, n_mode;
    logic [7:0]                  r_foc, n_foc;
    logic [ets_pkg::LEN_W-1:0]   r_run, n_run;
    logic                        r_ovf, n_ovf;
    logic [1:0]                  r_kp, n_kp;

    logic            fire;
    logic            p_v, q_v, idle_go;
    ets_pkg::t_token p_tok, q_tok, run_tok;
    ets_pkg::t_kind  pk;

    assign fire    = r_in_valid && i_room;
    assign o_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
            r_eoi  <= i_eoi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ets_pkg::MODE_IDLE;
            r_foc  <= '0;
            r_run  <= '0;
            r_ovf  <= 1'b0;
            r_kp   <= KP_NONE;
        end else if (fire) begin
            r_mode <= n_mode;
            r_foc  <= n_foc;
            r_run  <= n_run;
            r_ovf  <= n_ovf;
            r_kp   <= n_kp;
        end
    end

    always_comb begin
        run_tok = mk_tok((r_mode == ets_pkg::MODE_IDENT) ?
                         ((r_kp == KP_FN) ? ets_pkg::K_FN : ets_pkg::K_IDENT) :
                         ets_pkg::K_INT, r_run, r_ovf);
    end

    assign pk = pair_kind(r_foc, r_byte);

    always_comb begin
        n_mode  = r_mode;
        n_foc   = r_foc;
        n_run   = r_run;
        n_ovf   = r_ovf;
        n_kp    = r_kp;
        p_v     = 1'b0;
        p_tok   = '0;
        q_v     = 1'b0;
        q_tok   = '0;
        idle_go = 1'b0;
        if (r_eoi) begin
            if (r_mode == ets_pkg::MODE_IDENT || r_mode == ets_pkg::MODE_INT) begin
                p_v   = 1'b1;
                p_tok = run_tok;
            end else if (r_mode == ets_pkg::MODE_OP) begin
                p_v   = 1'b1;
                p_tok = mk_tok(single_kind(r_foc), ets_pkg::LEN_W'(1), 1'b0);
            end
            q_v    = 1'b1;
            q_tok  = mk_tok(ets_pkg::K_EOF, '0, 1'b0);
            n_mode = ets_pkg::MODE_IDLE;
        end else begin
            unique case (r_mode)
                ets_pkg::MODE_COMMENT: begin
                    if (r_byte == CH_LF) n_mode = ets_pkg::MODE_IDLE;
                end
                ets_pkg::MODE_IDENT: begin
                    if (is_alpha(r_byte) || is_digit(r_byte) || r_byte == CH_UNDER) begin
                        if (r_run < LEN_CAP) n_run = r_run + 1'b1;
                        else                 n_ovf = 1'b1;
                        n_kp = (r_kp == KP_F && r_byte == CH_N) ? KP_FN : KP_NOT;
                    end else begin
                        p_v     = 1'b1;
                        p_tok   = run_tok;
                        idle_go = 1'b1;
                    end
                end
                ets_pkg::MODE_INT: begin
                    if (is_digit(r_byte)) begin
                        if (r_run < LEN_CAP) n_run = r_run + 1'b1;
                        else                 n_ovf = 1'b1;
                    end else begin
                        p_v     = 1'b1;
                        p_tok   = run_tok;
                        idle_go = 1'b1;
                    end
                end
                ets_pkg::MODE_OP: begin
                    p_v = 1'b1;
                    if (pk != ets_pkg::K_INVALID) begin
                        p_tok  = mk_tok(pk, ets_pkg::LEN_W'(2), 1'b0);
                        n_mode = ets_pkg::MODE_IDLE;
                    end else begin
                        p_tok   = mk_tok(single_kind(r_foc), ets_pkg::LEN_W'(1), 1'b0);
                        idle_go = 1'b1;
                    end
                end
                default: idle_go = 1'b1;
            endcase

            // byte seen between tokens (possibly the one that ended a token)
            if (idle_go) begin
                n_mode = ets_pkg::MODE_IDLE;
                if (is_space(r_byte)) begin
                    n_mode = ets_pkg::MODE_IDLE;
                end else if (r_byte == CH_HASH) begin
                    n_mode = ets_pkg::MODE_COMMENT;
                end else if (is_alpha(r_byte) || r_byte == CH_UNDER) begin
                    n_mode = ets_pkg::MODE_IDENT;
                    n_run  = ets_pkg::LEN_W'(1);
                    n_ovf  = 1'b0;
                    n_kp   = (r_byte == CH_F) ? KP_F : KP_NOT;
                end else if (is_digit(r_byte)) begin
                    n_mode = ets_pkg::MODE_INT;
                    n_run  = ets_pkg::LEN_W'(1);
                    n_ovf  = 1'b0;
                    n_kp   = KP_NOT;
                end else if (single_kind(r_byte) != ets_pkg::K_INVALID) begin
                    n_mode = ets_pkg::MODE_OP;
                    n_foc  = r_byte;
                end else begin
                    q_v   = 1'b1;
                    q_tok = mk_tok(immediate_kind(r_byte), ets_pkg::LEN_W'(1), 1'b0);
                end
            end
        end
    end

    // compact to slot order and mark the final token of the item
    always_comb begin
        o_push = '0;
        if (fire) begin
            if (p_v && q_v) begin
                o_push.cnt       = 2'd2;
                o_push.tok0      = p_tok;
                o_push.tok1      = q_tok;
                o_push.tok1.last = 1'b1;
            end else if (p_v) begin
                o_push.cnt       = 2'd1;
                o_push.tok0      = p_tok;
                o_push.tok0.last = 1'b1;
            end else if (q_v) begin
                o_push.cnt       = 2'd1;
                o_push.tok0      = q_tok;
                o_push.tok0.last = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/ets_token_fifo.sv -----
// Small token queue: takes up to two tokens per cycle, hands out one.
`default_nettype none

module ets_token_fifo (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  ets_pkg::t_push           i_push,
    output logic                     o_room,
    output logic                     o_valid,
    input  wire                      i_ready,
    output ets_pkg::t_token          o_token
);

    localparam int PTR_W = $clog2(ets_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(ets_pkg::FIFO_DEPTH + 1);

    ets_pkg::t_token r_mem [ets_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;
    assign o_room  = (r_cnt <= CNT_W'(ets_pkg::FIFO_DEPTH - 2));
    assign o_token = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) r_mem[r_wr] <= i_push.tok0;
        if (i_push.cnt == 2'd2) r_mem[r_wr + PTR_W'(1)] <= i_push.tok1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + PTR_W'(i_push.cnt);
            r_rd  <= r_rd + PTR_W'(pop);
            r_cnt <= r_cnt + CNT_W'(i_push.cnt) - CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

// ----- design/expression_token_scanner.sv -----
// Top level of the expression token scanner: byte stream in, token stream out.
// One source byte per input item (tdata), with tuser high meaning end of input
// (tdata is then ignored). Each item gives zero, one or two tokens; tlast marks
// the final token of an item. Whitespace and '#' comments up to a line feed are
// skipped. A byte enters an input register, one shallow decision step updates
// the scan state and writes its tokens into a four-entry queue that drives the
// output directly. Items are taken one per cycle as long as the queue holds two
// or fewer tokens; an item that gives two tokens takes an extra output transfer,
// so the sustained rate is one item per cycle when tokens average at most one
// per item, and is bounded by the single-token-per-cycle output port otherwise.
// With an empty queue the first token of an item is decoded from the input
// register and written into the queue, which presents it on the output.
// Lengths saturate at min(TOKEN_BUFFER-1, 2047) with too_long set.
`default_nettype none

module expression_token_scanner #(
    parameter int TOKEN_BUFFER = ets_pkg::TOKEN_BUFFER_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  wire  [7:0]   i_s_axis_tdata,   // [7:0] byte_req
    input  wire          i_s_axis_tuser,   // [0] end_of_input
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    output logic [ets_pkg::OUT_DATA_W-1:0] o_m_axis_tdata, // [4:0] token_kind,
                                           // [15:5] token_length, [16] too_long
    output logic         o_m_axis_tlast    // last token of the item
);

    ets_pkg::t_push  push;
    ets_pkg::t_token head;
    logic            room;

    ets_scan_core #(
        .TOKEN_BUFFER(TOKEN_BUFFER)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_eoi   (i_s_axis_tuser),
        .i_room  (room),
        .o_push  (push)
    );

    ets_token_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_token (head)
    );

    localparam int PAD_W = ets_pkg::OUT_DATA_W - ets_pkg::KIND_W - ets_pkg::LEN_W - 1;

    assign o_m_axis_tdata = {{PAD_W{1'b0}}, head.too_long, head.length, head.kind};
    assign o_m_axis_tlast = head.last;

    // two tokens from one item: only the second closes the item
    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.cnt == 2'd2 |-> (push.tok1.last && !push.tok0.last))
        else $error("token pair marked wrongly");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.cnt == 2'd1 |-> push.tok0.last)
        else $error("single token not marked last");

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && head.kind == ets_pkg::K_EOF) |->
        (o_m_axis_tlast && head.length == '0 && !head.too_long))
        else $error("eof token malformed");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !room |-> push.cnt == 2'd0)
        else $error("token written without queue room");

endmodule

`default_nettype wire
